// ----- rtl/core/csx_pkg.sv -----
// Shared types, constants and round functions of the ChaCha20 stream XOR block.
package csx_pkg;

  localparam int CSX_QUEUE_DEPTH = 4;
  localparam int CSX_HALF_STEPS  = 40;
  localparam int CSX_BLOCK_BITS  = 512;
  localparam int CSX_POS_W       = 6;
  localparam int CSX_CTR_W       = 32;
  localparam int CSX_IDX_W       = 3;
  localparam int CSX_CFG_W       = 64;

  localparam logic [CSX_IDX_W-1:0] CSX_REG_KEY0  = 3'd0;
  localparam logic [CSX_IDX_W-1:0] CSX_REG_KEY1  = 3'd1;
  localparam logic [CSX_IDX_W-1:0] CSX_REG_KEY2  = 3'd2;
  localparam logic [CSX_IDX_W-1:0] CSX_REG_KEY3  = 3'd3;
  localparam logic [CSX_IDX_W-1:0] CSX_REG_NONCE = 3'd4;

  localparam logic [31:0] CSX_SIGMA0 = 32'h61707865;
  localparam logic [31:0] CSX_SIGMA1 = 32'h3320646e;
  localparam logic [31:0] CSX_SIGMA2 = 32'h79622d32;
  localparam logic [31:0] CSX_SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] csx_words_t;
  typedef logic [3:0][63:0]  csx_key_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } csx_in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } csx_out_t;

  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic [CSX_POS_W-1:0] pos;
    logic [CSX_CTR_W-1:0] ctr;
  } csx_entry_t;

  typedef struct packed {
    logic                 start;
    logic                 abort;
    logic [CSX_CTR_W-1:0] ctr;
  } csx_gen_ctl_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [CSX_CTR_W-1:0] ctr;
  } csx_gen_sts_t;

  function automatic csx_words_t csx_init_state(csx_key_t key, logic [63:0] nonce,
                                                logic [CSX_CTR_W-1:0] ctr);
    csx_words_t s;
    s[0] = CSX_SIGMA0;
    s[1] = CSX_SIGMA1;
    s[2] = CSX_SIGMA2;
    s[3] = CSX_SIGMA3;
    for (int k = 0; k < 4; k++) begin
      s[4 + 2 * k] = key[k][31:0];
      s[5 + 2 * k] = key[k][63:32];
    end
    s[12] = ctr;
    s[13] = 32'd0;
    s[14] = nonce[31:0];
    s[15] = nonce[63:32];
    return s;
  endfunction

  // Half of four quarter rounds: the first half rotates by 16 and 12,
  // the second by 8 and 7. Diagonal rounds shift the b, c, d columns.
  function automatic csx_words_t csx_half_round(csx_words_t s, logic diag, logic second);
    csx_words_t r;
    logic [1:0] jj;
    logic [1:0] sh;
    logic [3:0] ia, ib, ic, id;
    logic [31:0] va, vb, vc, vd;
    r = s;
    for (int j = 0; j < 4; j++) begin
      jj = 2'(j);
      sh = {1'b0, diag};
      ia = {2'b00, jj};
      ib = {2'b01, 2'(jj + sh)};
      ic = {2'b10, 2'(jj + {diag, 1'b0})};
      id = {2'b11, 2'(jj + {diag, diag})};
      va = s[ia] + s[ib];
      vd = s[id] ^ va;
      vd = second ? {vd[23:0], vd[31:24]} : {vd[15:0], vd[31:16]};
      vc = s[ic] + vd;
      vb = s[ib] ^ vc;
      vb = second ? {vb[24:0], vb[31:25]} : {vb[19:0], vb[31:20]};
      r[ia] = va;
      r[ib] = vb;
      r[ic] = vc;
      r[id] = vd;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/csx_front.sv -----
// Front end: accepts input words and tags each with its block counter and byte position.
module csx_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  csx_pkg::csx_in_t   in_data,
  input  logic               q_full,
  output logic               q_push,
  output csx_pkg::csx_entry_t q_entry
);
  import csx_pkg::*;

  logic [CSX_CTR_W-1:0] blk_ctr_r, blk_ctr_nxt, ctr_eff;
  logic [CSX_POS_W-1:0] pos_r, pos_nxt, pos_eff;

  assign q_push  = in_valid && !q_full;
  // first byte restarts the stream at counter 1, position 0
  assign ctr_eff = in_data.first_byte ? CSX_CTR_W'(1) : blk_ctr_r;
  assign pos_eff = in_data.first_byte ? '0 : pos_r;

  always_comb begin
    q_entry.data = in_data.data_byte;
    q_entry.last = in_data.last_byte;
    q_entry.pos  = pos_eff;
    q_entry.ctr  = (pos_eff == '0) ? ctr_eff : ctr_eff - CSX_CTR_W'(1);
    blk_ctr_nxt  = (pos_eff == '0) ? ctr_eff + CSX_CTR_W'(1) : ctr_eff;
    pos_nxt      = pos_eff + CSX_POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_ctr_r <= CSX_CTR_W'(1);
      pos_r     <= '0;
    end else if (q_push) begin
      blk_ctr_r <= blk_ctr_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

// ----- rtl/core/csx_fifo.sv -----
// Short queue of tagged words between the front end and the keystream back end.
module csx_fifo #(
  parameter int DEPTH = csx_pkg::CSX_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  csx_pkg::csx_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output csx_pkg::csx_entry_t head_data
);
  import csx_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  csx_entry_t             slot_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  // Wrap the pointers at the last slot so any depth works.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/csx_keygen.sv -----
// ChaCha20 block generator: one half-round step (column or diagonal) per cycle, then the final add.
module csx_keygen (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csx_pkg::csx_key_t     key,
  input  logic [63:0]           nonce,
  input  csx_pkg::csx_gen_ctl_t ctl,
  output csx_pkg::csx_gen_sts_t sts,
  output csx_pkg::csx_words_t   block
);
  import csx_pkg::*;

  localparam int STEP_W = $clog2(CSX_HALF_STEPS + 1);

  logic                 busy_r, done_r;
  logic [STEP_W-1:0]    step_r;
  logic [CSX_CTR_W-1:0] gen_ctr_r;
  csx_words_t           work_r, block_r, init_w;
  logic                 finish;

  assign init_w = csx_init_state(key, nonce, gen_ctr_r);
  assign finish = busy_r && (step_r == STEP_W'(CSX_HALF_STEPS));

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.ctr  = gen_ctr_r;
  assign block    = block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.abort) begin
        busy_r <= 1'b0;
      end else if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !ctl.abort) begin
      step_r    <= '0;
      gen_ctr_r <= ctl.ctr;
      work_r    <= csx_init_state(key, nonce, ctl.ctr);
    end else if (finish) begin
      for (int i = 0; i < 16; i++) block_r[i] <= work_r[i] + init_w[i];
    end else if (busy_r) begin
      work_r <= csx_half_round(work_r, step_r[1], step_r[0]);
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

// ----- rtl/core/csx_back.sv -----
// Back end: holds current and prefetched keystream blocks and XORs queued words.
module csx_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  head_valid,
  input  csx_pkg::csx_entry_t   head_data,
  output logic                  q_pop,
  output csx_pkg::csx_gen_ctl_t gen_ctl,
  input  csx_pkg::csx_gen_sts_t gen_sts,
  input  csx_pkg::csx_words_t   gen_block,
  output logic                  out_valid,
  input  logic                  out_stall,
  output csx_pkg::csx_out_t     out_data
);
  import csx_pkg::*;

  logic [CSX_BLOCK_BITS-1:0] cur_ks_r, nxt_ks_r, sel_ks;
  logic [CSX_CTR_W-1:0]      cur_ctr_r, nxt_ctr_r, want_ctr;
  logic                      cur_valid_r, cur_stale_r, nxt_valid_r;
  logic                      out_valid_r;
  csx_out_t                  out_data_r;
  logic                      match_cur, match_nxt, out_free, want_valid, present;
  logic                      take_done;
  logic [CSX_POS_W+2:0]      bit_off;

  // a block position of 0 needs a block made since the last key change
  assign match_cur = cur_valid_r && (cur_ctr_r == head_data.ctr) &&
                     ((head_data.pos != '0) || !cur_stale_r);
  assign match_nxt = nxt_valid_r && (nxt_ctr_r == head_data.ctr);
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = head_valid && (match_cur || match_nxt) && out_free;
  assign sel_ks    = match_cur ? cur_ks_r : nxt_ks_r;
  assign bit_off   = {head_data.pos, 3'b000};
  assign take_done = gen_sts.done && !cfg_we;

  always_comb begin
    if (head_valid && !match_cur && !match_nxt) begin
      want_valid = 1'b1;
      want_ctr   = head_data.ctr;
    end else begin
      want_valid = cur_valid_r;
      want_ctr   = cur_ctr_r + CSX_CTR_W'(1);
    end
    present = (nxt_valid_r && (nxt_ctr_r == want_ctr)) ||
              (gen_sts.done && (gen_sts.ctr == want_ctr));
    gen_ctl.abort = cfg_we;
    gen_ctl.ctr   = want_ctr;
    gen_ctl.start = want_valid && !present && !cfg_we &&
                    (!gen_sts.busy || (gen_sts.ctr != want_ctr));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_stale_r <= 1'b0;
      nxt_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (q_pop && !match_cur) begin
        cur_valid_r <= 1'b1;
        cur_stale_r <= 1'b0;
        nxt_valid_r <= 1'b0;
      end
      if (take_done) nxt_valid_r <= 1'b1;
      if (cfg_we) begin
        cur_stale_r <= 1'b1;
        nxt_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.result_byte <= head_data.data ^ sel_ks[bit_off +: 8];
      out_data_r.result_last <= head_data.last;
      if (!match_cur) begin
        cur_ks_r  <= nxt_ks_r;
        cur_ctr_r <= nxt_ctr_r;
      end
    end
    if (take_done) begin
      nxt_ks_r  <= gen_block;
      nxt_ctr_r <= gen_sts.ctr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/chacha20_stream_xor.sv -----
// Top level of the ChaCha20 stream XOR block: config registers and the front/back pipeline.
//
// Usage: write the four key words and the nonce on the cfg port while the block is idle,
// then stream message words on the in_ channel; each in word yields exactly one out word
// carrying data XOR keystream and a copy of the last-byte flag. Encrypt and decrypt match.
// A word flagged first_byte restarts the block counter at 1 and the byte position at 0.
// Channels: valid/stall on both sides; a word moves when valid is high and stall is low.
// The front end tags each word with its block counter and position and pushes it into a
// four-entry queue; in_stall is high only while that queue is full.
// The back end pulls tagged words, XORs them with the matching keystream block and holds
// the result in an output register, so new words keep flowing while out_stall is high
// until the queue fills.
// Keystream: the generator builds each 64-byte block from a load, 40 half-round steps of
// four parallel quarter rounds and a final add. The next block is prefetched while the
// current one is used, so throughput is one word per cycle while out_stall is low.
// Words pass the queue and output register once their block is ready; after reset, a key
// change or a first_byte restart, a word that needs a new block waits for it to be made.
// Reset (synchronous, rst_n low) clears keys and nonce to 0, sets counter 1, position 0,
// and empties the queue and both keystream buffers.
module chacha20_stream_xor #(
  parameter int QUEUE_DEPTH = csx_pkg::CSX_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  csx_pkg::csx_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output csx_pkg::csx_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [csx_pkg::CSX_IDX_W-1:0]   cfg_idx,
  input  logic [csx_pkg::CSX_CFG_W-1:0]   cfg_wdata
);
  import csx_pkg::*;

  csx_key_t     key_r;
  logic [63:0]  nonce_r;
  csx_entry_t   push_entry, head_entry;
  logic         q_push, q_pop, q_full, head_valid;
  csx_gen_ctl_t gen_ctl;
  csx_gen_sts_t gen_sts;
  csx_words_t   gen_block;

  // Config registers: indexes past the nonce are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CSX_REG_KEY0:  key_r[0] <= cfg_wdata;
        CSX_REG_KEY1:  key_r[1] <= cfg_wdata;
        CSX_REG_KEY2:  key_r[2] <= cfg_wdata;
        CSX_REG_KEY3:  key_r[3] <= cfg_wdata;
        CSX_REG_NONCE: nonce_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stall the input only when the queue has no room.
  assign in_stall = q_full;

  csx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  csx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_entry)
  );

  // A config write aborts any block in progress and drops the prefetched block;
  // the current block stays in use for the rest of its bytes.
  csx_keygen u_keygen (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (key_r),
    .nonce (nonce_r),
    .ctl   (gen_ctl),
    .sts   (gen_sts),
    .block (gen_block)
  );

  csx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .head_valid (head_valid),
    .head_data  (head_entry),
    .q_pop      (q_pop),
    .gen_ctl    (gen_ctl),
    .gen_sts    (gen_sts),
    .gen_block  (gen_block),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- bench/chacha20_stream_xor_tb.sv -----
// Self-checking bench for chacha20_stream_xor: byte stream XOR against an in-bench ChaCha20 model.
module chacha20_stream_xor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csx_pkg::*;

  // Cycles to let pass once the last expected word is back: covers an on-demand
  // block build plus the output pipe.
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int WORDS_PER_PHASE = 120;

  // Keeps its own copy of the key, nonce and keystream state, predicts one result
  // word per accepted input word and checks result words in order.
  class xor_stream_checker;
    logic [63:0] key_words [4] = '{default: '0};
    logic [63:0] nonce_reg = '0;
    logic [31:0] block_ctr = 32'd1;
    logic [5:0]  byte_pos  = '0;
    logic [7:0]  ks_bytes [64];
    logic [31:0] st [16];
    csx_out_t    expected_bytes [$];
    int          errors = 0;

    function logic [31:0] rotl(logic [31:0] x, int s);
      return (x << s) | (x >> (32 - s));
    endfunction

    function void quarter(int a, int b, int c, int d);
      st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 16);
      st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 12);
      st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 8);
      st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 7);
    endfunction

    function void make_keystream_block();
      logic [31:0] init [16];
      logic [31:0] v;
      init[0] = 32'h61707865;
      init[1] = 32'h3320646e;
      init[2] = 32'h79622d32;
      init[3] = 32'h6b206574;
      for (int k = 0; k < 4; k++) begin
        init[4 + 2 * k] = key_words[k][31:0];
        init[5 + 2 * k] = key_words[k][63:32];
      end
      init[12] = block_ctr;
      init[13] = 32'd0;
      init[14] = nonce_reg[31:0];
      init[15] = nonce_reg[63:32];
      st = init;
      // Ten double rounds: columns, then diagonals.
      repeat (10) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        v = st[i] + init[i];
        for (int j = 0; j < 4; j++) ks_bytes[4 * i + j] = v[8 * j +: 8];
      end
    endfunction

    function void set_reg(logic [CSX_IDX_W-1:0] idx, logic [63:0] value);
      case (idx)
        CSX_REG_KEY0:  key_words[0] = value;
        CSX_REG_KEY1:  key_words[1] = value;
        CSX_REG_KEY2:  key_words[2] = value;
        CSX_REG_KEY3:  key_words[3] = value;
        CSX_REG_NONCE: nonce_reg = value;
        default: ;
      endcase
    endfunction

    function void predict_word(csx_in_t w);
      csx_out_t e;
      if (w.first_byte) begin
        block_ctr = 32'd1;
        byte_pos  = '0;
      end
      if (byte_pos == 0) begin
        make_keystream_block();
        block_ctr++;
      end
      e.result_byte = w.data_byte ^ ks_bytes[byte_pos];
      e.result_last = w.last_byte;
      expected_bytes.push_back(e);
      byte_pos++;
    endfunction

    function void check_word(csx_out_t got);
      csx_out_t e;
      if (expected_bytes.size() == 0) begin
        $error("result word %h with nothing expected", got);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (got.result_byte !== e.result_byte) begin
        $error("result_byte: expected %h, got %h", e.result_byte, got.result_byte);
        errors++;
      end
      if (got.result_last !== e.result_last) begin
        $error("result_last: expected %b, got %b", e.result_last, got.result_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  csx_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  csx_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CSX_IDX_W-1:0] cfg_idx = '0;
  logic [CSX_CFG_W-1:0] cfg_wdata = '0;

  // Percent chance per cycle that the sender idles / the receiver stalls.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  // Long receiver hold-off, raised by its own process.
  logic hold_on = 1'b0;

  xor_stream_checker sb = new;

  chacha20_stream_xor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Receiver: check a word on every edge where it moves (values seen here are the
  // pre-edge ones), then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one word; idle first at random, then hold it until the block takes it.
  // Valid stays high on back-to-back words, so it is never dropped and raised in one step.
  task automatic send_word(input logic [7:0] data, input logic first, input logic last);
    csx_in_t w;
    w.data_byte  = data;
    w.first_byte = first;
    w.last_byte  = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.predict_word(w);
  endtask

  // Drop valid and wait for every predicted word to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write one register; the caller drops the write enable after the batch.
  task automatic write_reg(input logic [CSX_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Load key and nonce, then hit the unused indexes, which the block must ignore.
  task automatic load_keys(input logic [3:0][63:0] key, input logic [63:0] nonce);
    write_reg(CSX_REG_KEY0, key[0]);
    write_reg(CSX_REG_KEY1, key[1]);
    write_reg(CSX_REG_KEY2, key[2]);
    write_reg(CSX_REG_KEY3, key[3]);
    write_reg(CSX_REG_NONCE, nonce);
    for (int k = 1; k <= 3; k++)
      write_reg(CSX_IDX_W'(CSX_REG_NONCE + k), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  task automatic hold_receiver(input int cycles);
    hold_on <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  // Mostly well-formed messages with random bytes; some isolated words with random
  // flags, some messages missing their first or last marker. Long messages cross
  // several keystream blocks.
  task automatic run_stream(input int n_words);
    int   sent;
    int   len;
    int   kind;
    logic has_first;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        send_word(8'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = (kind < 17) ? $urandom_range(1, 80) : $urandom_range(100, 200);
        has_first = (kind != 2);
        for (int i = 0; i < len && sent < n_words; i++) begin
          send_word(8'($urandom), has_first && (i == 0), (i == len - 1) && (kind != 3));
          sent++;
        end
      end
    end
  endtask

  function automatic logic [3:0][63:0] random_key();
    logic [3:0][63:0] k;
    for (int i = 0; i < 4; i++) k[i] = {$urandom, $urandom};
    return k;
  endfunction

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_600_000;
    $display("chacha20_stream_xor regression: fail");
    $finish;
  end

  initial begin
    logic [3:0][63:0] key;
    logic [63:0]      nonce;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, zero key from reset. Start with no first marker at all: the stream
    // must begin at counter 1, position 0. Data extremes on the way.
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'ha5, 1'b0, 1'b0);
    send_word(8'h5a, 1'b0, 1'b1);
    // Words after a last marker with no new first: keystream just continues.
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    // One-word message, first and last together.
    send_word(8'h3c, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h01, 1'b0, 1'b0);
    send_word(8'h7f, 1'b0, 1'b1);

    // Random phases, each under a new key/nonce and a different idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph)
        0: begin key = '1; nonce = '1; end
        1: begin key = random_key(); nonce = {$urandom, $urandom}; end
        2: begin key = random_key(); nonce = '0; end
        default: begin key = random_key(); nonce = {$urandom, $urandom}; end
      endcase
      load_keys(key, nonce);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase

      // Keys changed in mid-block: the block already built stays in use, so carry on
      // without a first marker for a few words.
      repeat (3) send_word(8'($urandom), 1'b0, 1'b0);

      if (ph == 0) begin
        // Hold the receiver off for a long stretch while words keep coming, so the
        // queue fills and the input stalls.
        fork
          hold_receiver(HOLD_CYCLES);
        join_none
        run_stream(WORDS_PER_PHASE);
      end else if (ph == 1) begin
        // Pause the sender halfway until every word is back.
        run_stream(WORDS_PER_PHASE / 2);
        drain_results();
        run_stream(WORDS_PER_PHASE / 2);
      end else begin
        run_stream(WORDS_PER_PHASE);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("chacha20_stream_xor regression: pass");
    else
      $display("chacha20_stream_xor regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/csx_pkg.sv
rtl/core/csx_front.sv
rtl/core/csx_fifo.sv
rtl/core/csx_keygen.sv
rtl/core/csx_back.sv
rtl/core/chacha20_stream_xor.sv
bench/chacha20_stream_xor_tb.sv
